>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file dsha_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/core/dsha_pkg.sv
`default_nettype none
package dsha_pkg;
	localparam logic [31:0] PAD_MARK   = 32'h80000000;
	localparam logic [31:0] LEN_FIRST  = 32'h00000280;
	localparam logic [31:0] LEN_SECOND = 32'h00000100;

	localparam logic [2:0] REG_MID01 = 3'd0;
	localparam logic [2:0] REG_MID23 = 3'd1;
	localparam logic [2:0] REG_MID45 = 3'd2;
	localparam logic [2:0] REG_MID67 = 3'd3;
	localparam logic [2:0] REG_TAIL01 = 3'd4;
	localparam logic [2:0] REG_TAIL2 = 3'd5;

	localparam logic [255:0] INIT_VAL = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	function automatic logic [31:0] rk(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[t];
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/double_sha256_nonce_hasher.sv
// From nonce word accepted to hash word valid: 64 rounds and one digest add per
// compression, two compressions.
// The hash word is held until it is taken, then the sequencer returns to idle before
// the next nonce is accepted, so a new nonce waits until the last hash word is taken.
// The shared round unit runs both compressions one after the other.
// Reset (arst_n low, asynchronous) zeroes mid_q and tail_q; the sequencer goes idle.
`default_nettype none
module double_sha256_nonce_hasher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // nonce
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [255:0] m_tdata    // hash_w0 .. hash_w7, lowest first
);
	logic [255:0] mid_q;
	logic [95:0]  tail_q;
	dsha_pkg::state_t state_q;
	logic [5:0]   rnd_q;
	logic         second_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic [255:0] out_q;

	logic [2:0] ridx;
	assign ridx = paddr[5:3];
	assign pready = 1'b1;

	always_comb begin
		case (ridx)
			dsha_pkg::REG_MID01:  prdata = mid_q[63:0];
			dsha_pkg::REG_MID23:  prdata = mid_q[127:64];
			dsha_pkg::REG_MID45:  prdata = mid_q[191:128];
			dsha_pkg::REG_MID67:  prdata = mid_q[255:192];
			dsha_pkg::REG_TAIL01: prdata = tail_q[63:0];
			dsha_pkg::REG_TAIL2:  prdata = {32'd0, tail_q[95:64]};
			default:              prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= '0;
			tail_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				dsha_pkg::REG_MID01:  mid_q[63:0] <= pwdata;
				dsha_pkg::REG_MID23:  mid_q[127:64] <= pwdata;
				dsha_pkg::REG_MID45:  mid_q[191:128] <= pwdata;
				dsha_pkg::REG_MID67:  mid_q[255:192] <= pwdata;
				dsha_pkg::REG_TAIL01: tail_q[63:0] <= pwdata;
				dsha_pkg::REG_TAIL2:  tail_q[95:64] <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Shared round unit: one SHA-256 round and one schedule word per cycle in the run state.
	logic [31:0] sig1, ch, t1, sig0, maj, t2, s0, s1, wn, x, y, e, a;
	always_comb begin
		a = v_q[0];
		e = v_q[4];
		x = w_q[1];
		y = w_q[14];
		sig1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		ch = v_q[6] ^ (e & (v_q[5] ^ v_q[6]));
		t1 = v_q[7] + sig1 + ch + dsha_pkg::rk(rnd_q) + w_q[0];
		sig0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		maj = (a & v_q[1]) | (v_q[2] & (a | v_q[1]));
		t2 = sig0 + maj;
		s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
		s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	assign s_tready = (state_q == dsha_pkg::ST_IDLE);
	assign m_tvalid = (state_q == dsha_pkg::ST_OUT);
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsha_pkg::ST_IDLE;
			rnd_q <= '0;
			second_q <= 1'b0;
		end else begin
			case (state_q)
				dsha_pkg::ST_IDLE: if (s_tvalid) begin
					state_q <= dsha_pkg::ST_RUN;
					rnd_q <= '0;
					second_q <= 1'b0;
				end
				dsha_pkg::ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= dsha_pkg::ST_FIN;
				end
				dsha_pkg::ST_FIN: begin
					second_q <= 1'b1;
					state_q <= second_q ? dsha_pkg::ST_OUT : dsha_pkg::ST_RUN;
				end
				dsha_pkg::ST_OUT: if (m_tready) state_q <= dsha_pkg::ST_IDLE;
				default: state_q <= dsha_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dsha_pkg::ST_IDLE: begin
				w_q[0] <= tail_q[31:0];
				w_q[1] <= tail_q[63:32];
				w_q[2] <= tail_q[95:64];
				w_q[3] <= s_tdata;
				w_q[4] <= dsha_pkg::PAD_MARK;
				for (int i = 5; i < 15; i++) w_q[i] <= '0;
				w_q[15] <= dsha_pkg::LEN_FIRST;
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= mid_q[32*i +: 32];
					h_q[i] <= mid_q[32*i +: 32];
				end
			end
			dsha_pkg::ST_RUN: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			dsha_pkg::ST_FIN: begin
				// Digest add; the first digest becomes the second block.
				for (int i = 0; i < 8; i++) begin
					w_q[i] <= h_q[i] + v_q[i];
					v_q[i] <= dsha_pkg::INIT_VAL[32*i +: 32];
					h_q[i] <= dsha_pkg::INIT_VAL[32*i +: 32];
					out_q[32*i +: 32] <= h_q[i] + v_q[i];
				end
				w_q[8] <= dsha_pkg::PAD_MARK;
				for (int i = 9; i < 15; i++) w_q[i] <= '0;
				w_q[15] <= dsha_pkg::LEN_SECOND;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/core/dsha_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dsha_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [255:0] m_tdata
);
	`ASSERT_IMPL(a_excl, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready && !m_tvalid)
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_NEXT(a_free, clk, arst_n, m_tvalid && m_tready, s_tready)
endmodule
bind double_sha256_nonce_hasher dsha_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire
